[hdl/sfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, codes and controller/datapath link types for the serial
// frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 60;
  localparam int FRAME_SLOTS_DEF = 4;

  localparam int DATA_W       = 8;
  localparam int FRAME_SIZE_W = 6;
  localparam int TICK_W       = 16;
  localparam int SUM_W        = 16;
  localparam int OUT_DATA_W   = 16;

  localparam logic [DATA_W-1:0] HDR_FIRST     = 8'hDE;
  localparam logic [DATA_W-1:0] HDR_SECOND    = 8'h5B;
  localparam logic [SUM_W-1:0]  SUM_START     = 16'h1021;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd300;

  typedef enum logic [1:0] {
    FUNC_BYTE    = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_RELEASE = 2'd2
  } func_t;

  typedef struct packed {
    logic item_fire;
    logic size_load;
    logic data_load;
    logic chk_hi_load;
    logic frame_ok;
    logic out_load;
  } sfr_cmd_t;

  typedef struct packed {
    logic timed_out;
    logic hdr_first;
    logic hdr_second;
    logic size_ok;
    logic size_zero;
    logic data_done;
    logic sum_match;
    logic emit_last;
    logic out_free;
  } sfr_sts_t;

  function automatic logic [SUM_W-1:0] sum_step(input logic [SUM_W-1:0] sum,
                                                input logic [DATA_W-1:0] b);
    sum_step = {sum[SUM_W-2:0], sum[SUM_W-1]} ^ {{(SUM_W-DATA_W){1'b0}}, b};
  endfunction

endpackage

[hdl/serial_frame_receiver_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_core
// Serial frame deframer: header hunt, rotate-XOR checksum, slot tally and
// payload burst out of a frame buffer.
// ----------------------------------------------------------------------------
// Output path: after the last checksum byte, the buffer read register, then the output register.
// Throughput: one input transaction per cycle while parsing; a burst reads
// each result through the buffer read register, input held off meanwhile.
// Reset: synchronous, active low; parser hunts, idle and slot counters clear, timeout 300.
// Frame buffer is not cleared.
// ----------------------------------------------------------------------------
module serial_frame_receiver_core import sfr_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int FRAME_SLOTS = FRAME_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TICK_W-1:0]     cfg_data,     // timeout_ticks
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,     // [7:0] data_byte
  input  logic [1:0]            in_tuser,     // [1:0] func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,    // [7:0] payload_byte, [13:8] frame_size
  output logic                  out_tlast,
  output logic                  out_tuser     // [0] empty_frame
);

  sfr_cmd_t cmd;
  sfr_sts_t sts;

  assign cfg_ready = 1'b1;

  sfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

[hdl/sfr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_ctrl
// Frame parser and burst sequencer state machine; drives datapath commands.
// ----------------------------------------------------------------------------
module sfr_ctrl import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic [1:0]  in_tuser,
  output logic        in_tready,
  input  sfr_sts_t    sts,
  output sfr_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_HUNT,
    S_HDR,
    S_SIZE,
    S_DATA,
    S_CHK_HI,
    S_CHK_LO,
    S_EMIT_RD,
    S_EMIT_WR
  } state_t;

  state_t state_r, state_nxt, eff_state;
  logic   in_tready_r;
  logic   fire;
  logic   byte_fire;

  assign in_tready = in_tready_r;
  assign fire      = in_tvalid && in_tready_r;
  assign byte_fire = fire && (func_t'(in_tuser) == FUNC_BYTE);
  assign eff_state = sts.timed_out ? S_HUNT : state_r;

  always_comb begin
    cmd           = '0;
    cmd.item_fire = fire;
    state_nxt     = state_r;
    unique case (state_r)
      S_EMIT_RD: begin
        state_nxt = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sts.emit_last ? S_HUNT : S_EMIT_RD;
        end
      end
      default: begin
        if (byte_fire) begin
          unique case (eff_state)
            S_HUNT: begin
              state_nxt = sts.hdr_first ? S_HDR : S_HUNT;
            end
            S_HDR: begin
              state_nxt = sts.hdr_second ? S_SIZE : S_HUNT;
            end
            S_SIZE: begin
              if (sts.size_ok) begin
                cmd.size_load = 1'b1;
                state_nxt     = sts.size_zero ? S_CHK_HI : S_DATA;
              end else begin
                state_nxt = S_HUNT;
              end
            end
            S_DATA: begin
              cmd.data_load = 1'b1;
              if (sts.data_done) begin
                state_nxt = S_CHK_HI;
              end
            end
            S_CHK_HI: begin
              cmd.chk_hi_load = 1'b1;
              state_nxt       = S_CHK_LO;
            end
            S_CHK_LO: begin
              if (sts.sum_match) begin
                cmd.frame_ok = 1'b1;
                state_nxt    = S_EMIT_RD;
              end else begin
                state_nxt = S_HUNT;
              end
            end
            default: begin
              state_nxt = S_HUNT;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_HUNT;
      in_tready_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt != S_EMIT_RD) && (state_nxt != S_EMIT_WR);
    end
  end

endmodule

[hdl/sfr_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_datapath
// Checksum, counters, slot tally, payload memory and output register.
// ----------------------------------------------------------------------------
module sfr_datapath import sfr_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int FRAME_SLOTS = FRAME_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [TICK_W-1:0]     cfg_data,
  input  logic [DATA_W-1:0]     in_tdata,
  input  logic [1:0]            in_tuser,
  input  sfr_cmd_t              cmd,
  output sfr_sts_t              sts,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic                  out_tuser
);

  localparam int SZ_W = $clog2(MAX_PAYLOAD + 1);
  localparam int AW   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int PW   = $clog2(FRAME_SLOTS + 1);

  logic [TICK_W-1:0]       timeout_r;
  logic [TICK_W-1:0]       idle_r;
  logic [PW-1:0]           pending_r;
  logic [SUM_W-1:0]        sum_r;
  logic [DATA_W-1:0]       chk_hi_r;
  logic [SZ_W-1:0]         size_r;
  logic [SZ_W-1:0]         offset_r;
  logic [SZ_W-1:0]         emit_idx_r;
  logic [DATA_W-1:0]       mem [MAX_PAYLOAD];
  logic [DATA_W-1:0]       mem_q_r;
  logic                    out_valid_r;
  logic [DATA_W-1:0]       out_byte_r;
  logic [FRAME_SIZE_W-1:0] out_size_r;
  logic                    out_last_r;
  logic                    out_empty_r;
  logic [SZ_W-1:0]         offset_inc;
  logic [SZ_W-1:0]         emit_inc;
  logic                    emit_empty;

  assign offset_inc = offset_r + SZ_W'(1);
  assign emit_inc   = emit_idx_r + SZ_W'(1);
  assign emit_empty = (size_r == '0);

  always_comb begin
    sts.timed_out  = idle_r > timeout_r;
    sts.hdr_first  = in_tdata == HDR_FIRST;
    sts.hdr_second = in_tdata == HDR_SECOND;
    sts.size_ok    = (pending_r < PW'(FRAME_SLOTS)) &&
                     ({1'b0, in_tdata} <= 9'(MAX_PAYLOAD));
    sts.size_zero  = in_tdata == '0;
    sts.data_done  = offset_inc >= size_r;
    sts.sum_match  = sum_r == {chk_hi_r, in_tdata};
    sts.emit_last  = emit_empty || (emit_inc == size_r);
    sts.out_free   = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      idle_r      <= '0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        timeout_r <= cfg_data;
      end
      if (cmd.item_fire) begin
        unique case (func_t'(in_tuser))
          FUNC_BYTE: begin
            idle_r <= '0;
          end
          FUNC_TICK: begin
            if (idle_r != '1) begin
              idle_r <= idle_r + TICK_W'(1);
            end
          end
          FUNC_RELEASE: begin
            if (pending_r != '0) begin
              pending_r <= pending_r - PW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.frame_ok && (pending_r < PW'(FRAME_SLOTS))) begin
        pending_r <= pending_r + PW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.size_load) begin
      size_r   <= in_tdata[SZ_W-1:0];
      offset_r <= '0;
      sum_r    <= sum_step(SUM_START, in_tdata);
    end
    if (cmd.data_load) begin
      sum_r    <= sum_step(sum_r, in_tdata);
      offset_r <= offset_inc;
    end
    if (cmd.chk_hi_load) begin
      chk_hi_r <= in_tdata;
    end
    if (cmd.frame_ok) begin
      emit_idx_r <= '0;
    end else if (cmd.out_load) begin
      emit_idx_r <= emit_inc;
    end
    if (cmd.out_load) begin
      out_byte_r  <= emit_empty ? '0 : mem_q_r;
      out_size_r  <= FRAME_SIZE_W'(size_r);
      out_last_r  <= sts.emit_last;
      out_empty_r <= emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.data_load) begin
      mem[offset_r[AW-1:0]] <= in_tdata;
    end
    mem_q_r <= mem[emit_idx_r[AW-1:0]];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-FRAME_SIZE_W-DATA_W){1'b0}}, out_size_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;

endmodule
